// ===== sv/spbz_pkg.sv =====
package spbz_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int U_FRAC    = 16;

  // Datapath widths
  localparam int COORD_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DOT_W     = PROD_W + 1;
  localparam int DEN_W     = PROD_W;
  localparam int CSUM_W    = DOT_W + 3;
  localparam int DIST_W    = 34;
  localparam int RAD_W     = 2 * DIST_W;
  localparam int UQ_W      = U_FRAC + 1;
  localparam int FOOT_W    = UQ_W + 1 + DIFF_W;
  localparam int EX_W      = DIFF_W + 2;

  // Pipeline depths
  localparam int DIV_STEPS  = U_FRAC;
  localparam int SQRT_STEPS = DIST_W;

  localparam logic [COORD_W-1:0] SEG_DST_X_RST = COORD_W'(1) << FRAC_BITS;
  localparam logic [UQ_W-1:0]    U_ONE         = UQ_W'(1) << U_FRAC;
  localparam int                 U_HALF        = 1 << (U_FRAC - 1);

  typedef enum logic [1:0] {
    REG_SRC_X = 2'd0,
    REG_SRC_Y = 2'd1,
    REG_DST_X = 2'd2,
    REG_DST_Y = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ZONE_BEFORE = 2'd0,
    ZONE_IN     = 2'd1,
    ZONE_AFTER  = 2'd2
  } zone_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_res;
    logic [UQ_W-1:0]   proj_u;
    logic [DIST_W-1:0] star_dist;
    logic              star_far;
    logic [1:0]        zone_sign;
    logic              right_side;
    logic              point_in_zone;
    logic              point_in_zone_star;
    logic              box_in_zone;
    logic              box_in_zone_star;
    logic              on_segment;
    logic              degenerate;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] dst_x;
    logic signed [COORD_W-1:0] dst_y;
  } seg_t;

  // Center offset from src and segment vector
  typedef struct packed {
    logic signed [DIFF_W-1:0] px;
    logic signed [DIFF_W-1:0] py;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
  } geo_t;

  typedef struct packed {
    zone_e zone;
    logic  right;
    logic  bz;
    logic  bzs;
    logic  onseg;
    logic  degen;
  } flags_t;

endpackage

// ===== sv/spbz_front.sv =====
module spbz_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  spbz_pkg::in_t                 data_i,
  input  spbz_pkg::seg_t                seg_i,
  output logic                          valid_o,
  output logic [spbz_pkg::DEN_W-1:0]    dot_o,
  output logic [spbz_pkg::DEN_W-1:0]    den_o,
  output spbz_pkg::geo_t                geo_o,
  output spbz_pkg::flags_t              flags_o
);

  localparam int DW = spbz_pkg::DIFF_W;
  localparam int CW = spbz_pkg::CSUM_W;
  localparam int PW = spbz_pkg::PROD_W;
  localparam int OW = spbz_pkg::DOT_W;
  localparam int SW = spbz_pkg::SIZE_W;
  localparam int WP = SW + 1 + DW;  // size times offset
  // corner order: (-w,-h) (+w,-h) (+w,+h) (-w,+h)
  localparam logic [3:0] SGX_NEG = 4'b1001;
  localparam logic [3:0] SGY_NEG = 4'b0011;

  function automatic logic in_box(logic signed [31:0] q, logic signed [31:0] c,
                                  logic [SW-1:0] s);
    logic signed [33:0] df;
    logic [33:0]        mg;
    df = (34'(q) <<< 1) - (34'(c) <<< 1);
    mg = df[33] ? 34'(-df) : 34'(df);
    return mg <= 34'(s);
  endfunction

  logic [4:0] v_q;

  // ---------------- stage A: differences, bounds ----------------
  spbz_pkg::geo_t geo_a_d, geo_a_q;
  logic           bnd_a_d, bnd_a_q, inbox_a_d, inbox_a_q;
  logic [SW-1:0]  w_a_q, h_a_q;

  always_comb begin
    geo_a_d.px = DW'(data_i.center_x) - DW'(seg_i.src_x);
    geo_a_d.py = DW'(data_i.center_y) - DW'(seg_i.src_y);
    geo_a_d.dx = DW'(seg_i.dst_x) - DW'(seg_i.src_x);
    geo_a_d.dy = DW'(seg_i.dst_y) - DW'(seg_i.src_y);
    bnd_a_d = (seg_i.src_x < seg_i.dst_x
                 ? (data_i.center_x >= seg_i.src_x && data_i.center_x <= seg_i.dst_x)
                 : (data_i.center_x >= seg_i.dst_x && data_i.center_x <= seg_i.src_x)) &&
              (seg_i.src_y < seg_i.dst_y
                 ? (data_i.center_y >= seg_i.src_y && data_i.center_y <= seg_i.dst_y)
                 : (data_i.center_y >= seg_i.dst_y && data_i.center_y <= seg_i.src_y));
    inbox_a_d = (in_box(seg_i.src_x, data_i.center_x, data_i.box_width) &&
                 in_box(seg_i.src_y, data_i.center_y, data_i.box_height)) ||
                (in_box(seg_i.dst_x, data_i.center_x, data_i.box_width) &&
                 in_box(seg_i.dst_y, data_i.center_y, data_i.box_height));
  end

  // ---------------- stage B: products ----------------
  logic signed [PW-1:0] pxdx_q, pydy_q, dxdx_q, dydy_q, dxpy_q, dypx_q;
  logic signed [WP-1:0] wdx_q, hdy_q, wdy_q, hdx_q;
  spbz_pkg::geo_t       geo_b_q;
  logic                 bnd_b_q, inbox_b_q;

  // ---------------- stage C: sums ----------------
  logic signed [OW-1:0] dot_c_d, den_c_d, cr_c_d, dot_c_q, den_c_q, cr_c_q;
  logic signed [CW-1:0] a_c_d [4];
  logic signed [CW-1:0] b_c_d [4];
  logic signed [CW-1:0] a_c_q [4];
  logic signed [CW-1:0] b_c_q [4];
  spbz_pkg::geo_t       geo_c_q;
  logic                 bnd_c_q, inbox_c_q;

  always_comb begin
    dot_c_d = OW'(pxdx_q) + OW'(pydy_q);
    den_c_d = OW'(dxdx_q) + OW'(dydy_q);
    cr_c_d  = OW'(dxpy_q) - OW'(dypx_q);
    for (int k = 0; k < 4; k++) begin
      a_c_d[k] = (SGX_NEG[k] ? -CW'(wdx_q) : CW'(wdx_q)) +
                 (SGY_NEG[k] ? -CW'(hdy_q) : CW'(hdy_q));
      b_c_d[k] = (SGY_NEG[k] ? -CW'(hdx_q) : CW'(hdx_q)) -
                 (SGX_NEG[k] ? -CW'(wdy_q) : CW'(wdy_q));
    end
  end

  // ---------------- stage D: zone classification ----------------
  // corner tests run on doubled coordinates, so the sums carry a factor 2
  spbz_pkg::zone_e      zone_d_d, zone_d_q;
  spbz_pkg::zone_e      zs_d_d [4];
  spbz_pkg::zone_e      zs_d_q [4];
  logic [3:0]           rr_d_d, rr_d_q;
  logic                 right_d_q, onseg_d_q, inbox_d_q;
  logic signed [CW-1:0] dk, ck, den2;
  logic signed [OW-1:0] dot_d_q, den_d_q;
  spbz_pkg::geo_t       geo_d_q;

  always_comb begin
    if (dot_c_q <= 0)            zone_d_d = spbz_pkg::ZONE_BEFORE;
    else if (dot_c_q >= den_c_q) zone_d_d = spbz_pkg::ZONE_AFTER;
    else                         zone_d_d = spbz_pkg::ZONE_IN;
    den2 = CW'(den_c_q) <<< 1;
    dk   = '0;
    ck   = '0;
    for (int k = 0; k < 4; k++) begin
      dk = (CW'(dot_c_q) <<< 1) + a_c_q[k];
      ck = (CW'(cr_c_q) <<< 1) + b_c_q[k];
      if (dk <= 0)         zs_d_d[k] = spbz_pkg::ZONE_BEFORE;
      else if (dk >= den2) zs_d_d[k] = spbz_pkg::ZONE_AFTER;
      else                 zs_d_d[k] = spbz_pkg::ZONE_IN;
      rr_d_d[k] = ck < 0;
    end
  end

  // ---------------- stage E: box rules ----------------
  spbz_pkg::flags_t flags_e_d, flags_e_q;
  logic             bzs_any;
  logic [1:0]       nk;

  always_comb begin
    flags_e_d.zone  = zone_d_q;
    flags_e_d.right = right_d_q;
    flags_e_d.onseg = onseg_d_q;
    flags_e_d.degen = (geo_d_q.dx == '0) && (geo_d_q.dy == '0);
    flags_e_d.bz    = inbox_d_q;
    bzs_any         = 1'b0;
    nk              = '0;
    for (int k = 0; k < 4; k++) begin
      nk = 2'(k + 1);
      if (zs_d_q[k] == spbz_pkg::ZONE_IN) flags_e_d.bz = 1'b1;
      if (zs_d_q[k] != zs_d_q[nk])        flags_e_d.bz = 1'b1;
      if (rr_d_q[k] && zs_d_q[k] == spbz_pkg::ZONE_IN) bzs_any = 1'b1;
      if ((rr_d_q[k] || rr_d_q[nk]) && zs_d_q[k] != zs_d_q[nk]) bzs_any = 1'b1;
    end
    flags_e_d.bzs = flags_e_d.bz && (|rr_d_q) && bzs_any;
  end

  spbz_pkg::geo_t                 geo_e_q;
  logic [spbz_pkg::DEN_W-1:0]     dot_e_q, den_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_a_q   <= geo_a_d;
      bnd_a_q   <= bnd_a_d;
      inbox_a_q <= inbox_a_d;
      w_a_q     <= data_i.box_width;
      h_a_q     <= data_i.box_height;

      pxdx_q    <= geo_a_q.px * geo_a_q.dx;
      pydy_q    <= geo_a_q.py * geo_a_q.dy;
      dxdx_q    <= geo_a_q.dx * geo_a_q.dx;
      dydy_q    <= geo_a_q.dy * geo_a_q.dy;
      dxpy_q    <= geo_a_q.dx * geo_a_q.py;
      dypx_q    <= geo_a_q.dy * geo_a_q.px;
      wdx_q     <= $signed({1'b0, w_a_q}) * geo_a_q.dx;
      hdy_q     <= $signed({1'b0, h_a_q}) * geo_a_q.dy;
      wdy_q     <= $signed({1'b0, w_a_q}) * geo_a_q.dy;
      hdx_q     <= $signed({1'b0, h_a_q}) * geo_a_q.dx;
      geo_b_q   <= geo_a_q;
      bnd_b_q   <= bnd_a_q;
      inbox_b_q <= inbox_a_q;

      dot_c_q   <= dot_c_d;
      den_c_q   <= den_c_d;
      cr_c_q    <= cr_c_d;
      a_c_q     <= a_c_d;
      b_c_q     <= b_c_d;
      geo_c_q   <= geo_b_q;
      bnd_c_q   <= bnd_b_q;
      inbox_c_q <= inbox_b_q;

      zone_d_q  <= zone_d_d;
      zs_d_q    <= zs_d_d;
      rr_d_q    <= rr_d_d;
      right_d_q <= cr_c_q < 0;
      onseg_d_q <= bnd_c_q && (cr_c_q == '0);
      inbox_d_q <= inbox_c_q;
      dot_d_q   <= dot_c_q;
      den_d_q   <= den_c_q;
      geo_d_q   <= geo_c_q;

      flags_e_q <= flags_e_d;
      geo_e_q   <= geo_d_q;
      dot_e_q   <= dot_d_q[spbz_pkg::DEN_W-1:0];
      den_e_q   <= den_d_q[spbz_pkg::DEN_W-1:0];
    end
  end

  assign valid_o = v_q[4];
  assign dot_o   = dot_e_q;
  assign den_o   = den_e_q;
  assign geo_o   = geo_e_q;
  assign flags_o = flags_e_q;

endmodule

// ===== sv/spbz_div.sv =====
module spbz_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [spbz_pkg::DEN_W-1:0] dot_i,
  input  logic [spbz_pkg::DEN_W-1:0] den_i,
  input  spbz_pkg::geo_t             geo_i,
  input  spbz_pkg::flags_t           flags_i,
  output logic                       valid_o,
  output logic [spbz_pkg::U_FRAC-1:0] uq_o,
  output spbz_pkg::geo_t             geo_o,
  output spbz_pkg::flags_t           flags_o
);

  localparam int N  = spbz_pkg::DIV_STEPS;
  localparam int RW = spbz_pkg::DEN_W;

  typedef struct packed {
    logic [RW-1:0]              r;
    logic [RW-1:0]              den;
    logic [spbz_pkg::U_FRAC-1:0] uq;
    spbz_pkg::geo_t             geo;
    spbz_pkg::flags_t           flags;
  } div_st_t;

  div_st_t      st_in [N];
  div_st_t      st_d  [N];
  div_st_t      st_q  [N];
  logic [N-1:0] v_q;
  logic [RW:0]  r2;
  logic         ge;

  // one restoring quotient bit per stage; remainder stays below den
  always_comb begin
    st_in[0].r     = (flags_i.zone == spbz_pkg::ZONE_IN) ? dot_i : '0;
    st_in[0].den   = den_i;
    st_in[0].uq    = '0;
    st_in[0].geo   = geo_i;
    st_in[0].flags = flags_i;
    for (int i = 1; i < N; i++) st_in[i] = st_q[i-1];
    r2 = '0;
    ge = 1'b0;
    for (int i = 0; i < N; i++) begin
      r2        = {st_in[i].r, 1'b0};
      ge        = r2 >= {1'b0, st_in[i].den};
      st_d[i]   = st_in[i];
      st_d[i].r = ge ? RW'(r2 - {1'b0, st_in[i].den}) : r2[RW-1:0];
      st_d[i].uq = {st_in[i].uq[spbz_pkg::U_FRAC-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q <= st_d;
  end

  assign valid_o = v_q[N-1];
  assign uq_o    = st_q[N-1].uq;
  assign geo_o   = st_q[N-1].geo;
  assign flags_o = st_q[N-1].flags;

endmodule

// ===== sv/spbz_dist.sv =====
module spbz_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [spbz_pkg::U_FRAC-1:0]  uq_i,
  input  spbz_pkg::geo_t               geo_i,
  input  spbz_pkg::flags_t             flags_i,
  output logic                         valid_o,
  output logic [spbz_pkg::RAD_W-1:0]   dsq_o,
  output logic [spbz_pkg::UQ_W-1:0]    uq_o,
  output spbz_pkg::flags_t             flags_o
);

  localparam int FW = spbz_pkg::FOOT_W;
  localparam int EW = spbz_pkg::EX_W;
  localparam int MW = spbz_pkg::DIST_W;
  localparam int QW = 2 * MW;

  logic [3:0] v_q;

  // stage 1: clamp u, scale the segment vector
  logic [spbz_pkg::UQ_W-1:0]  uq1_d, uq1_q, uq2_q, uq3_q, uq4_q;
  logic signed [FW-1:0]       fx_q, fy_q;
  logic signed [spbz_pkg::DIFF_W-1:0] px1_q, py1_q;
  spbz_pkg::flags_t           fl1_q, fl2_q, fl3_q, fl4_q;

  always_comb begin
    case (flags_i.zone)
      spbz_pkg::ZONE_IN:    uq1_d = {1'b0, uq_i};
      spbz_pkg::ZONE_AFTER: uq1_d = spbz_pkg::U_ONE;
      default:              uq1_d = '0;
    endcase
  end

  // stage 2: rounded foot point, offset magnitude
  logic signed [FW-1:0] sx, sy;
  logic signed [EW-1:0] ex, ey;
  logic [MW-1:0]        mx_d, my_d, mx_q, my_q;

  always_comb begin
    sx   = (fx_q + FW'(spbz_pkg::U_HALF)) >>> spbz_pkg::U_FRAC;
    sy   = (fy_q + FW'(spbz_pkg::U_HALF)) >>> spbz_pkg::U_FRAC;
    ex   = EW'(px1_q) - EW'(sx);
    ey   = EW'(py1_q) - EW'(sy);
    mx_d = ex[EW-1] ? MW'(-ex) : MW'(ex);
    my_d = ey[EW-1] ? MW'(-ey) : MW'(ey);
  end

  // stage 3: squares, stage 4: sum
  logic [QW-1:0] sqx_q, sqy_q, dsq_q;
  logic [QW:0]   sum;

  assign sum = (QW+1)'(sqx_q) + (QW+1)'(sqy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uq1_q <= uq1_d;
      fx_q  <= $signed({1'b0, uq1_d}) * geo_i.dx;
      fy_q  <= $signed({1'b0, uq1_d}) * geo_i.dy;
      px1_q <= geo_i.px;
      py1_q <= geo_i.py;
      fl1_q <= flags_i;

      mx_q  <= mx_d;
      my_q  <= my_d;
      uq2_q <= uq1_q;
      fl2_q <= fl1_q;

      sqx_q <= mx_q * mx_q;
      sqy_q <= my_q * my_q;
      uq3_q <= uq2_q;
      fl3_q <= fl2_q;

      dsq_q <= sum[QW-1:0];
      uq4_q <= uq3_q;
      fl4_q <= fl3_q;
    end
  end

  assign valid_o = v_q[3];
  assign dsq_o   = dsq_q;
  assign uq_o    = uq4_q;
  assign flags_o = fl4_q;

endmodule

// ===== sv/spbz_sqrt.sv =====
module spbz_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [spbz_pkg::RAD_W-1:0]  dsq_i,
  input  logic [spbz_pkg::UQ_W-1:0]   uq_i,
  input  spbz_pkg::flags_t            flags_i,
  output logic                        valid_o,
  output logic [spbz_pkg::DIST_W-1:0] root_o,
  output logic [spbz_pkg::UQ_W-1:0]   uq_o,
  output spbz_pkg::flags_t            flags_o
);

  localparam int N  = spbz_pkg::SQRT_STEPS;
  localparam int RW = spbz_pkg::RAD_W;
  localparam int DW = spbz_pkg::DIST_W;
  localparam int MW = DW + 2;  // partial remainder

  typedef struct packed {
    logic [RW-1:0]             rad;
    logic [MW-1:0]             rem;
    logic [DW-1:0]             root;
    logic [spbz_pkg::UQ_W-1:0] uq;
    spbz_pkg::flags_t          flags;
  } sq_st_t;

  sq_st_t        st_in [N];
  sq_st_t        st_d  [N];
  sq_st_t        st_q  [N];
  logic [N-1:0]  v_q;
  logic [MW+1:0] rem2, trial;
  logic          ge;

  // one root bit per stage, two radicand bits shifted in each time
  always_comb begin
    st_in[0].rad   = dsq_i;
    st_in[0].rem   = '0;
    st_in[0].root  = '0;
    st_in[0].uq    = uq_i;
    st_in[0].flags = flags_i;
    for (int i = 1; i < N; i++) st_in[i] = st_q[i-1];
    rem2  = '0;
    trial = '0;
    ge    = 1'b0;
    for (int i = 0; i < N; i++) begin
      rem2          = {st_in[i].rem, st_in[i].rad[RW-1:RW-2]};
      trial         = {2'b00, st_in[i].root, 2'b01};
      ge            = rem2 >= trial;
      st_d[i]       = st_in[i];
      st_d[i].rad   = {st_in[i].rad[RW-3:0], 2'b00};
      st_d[i].rem   = ge ? MW'(rem2 - trial) : rem2[MW-1:0];
      st_d[i].root  = {st_in[i].root[DW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) st_q <= st_d;
  end

  assign valid_o = v_q[N-1];
  assign root_o  = st_q[N-1].root;
  assign uq_o    = st_q[N-1].uq;
  assign flags_o = st_q[N-1].flags;

endmodule

// ===== sv/segment_point_box_zone_query_unit.sv =====
// Point and box query against one wall segment. Each request carries a box
// center and full box size in Q16.16; the result gives the projection u of the
// center clamped to [0,1] (Q1.16), the distance from the center to the clamped
// foot point, the interior-only distance, the zone, the right-side and exact
// on-segment tests, and box zone flags from the four corners. All predicates
// are exact. The segment is held in four registers written through the config
// port; the user must write them only while no request is in flight; the block
// does not enforce it. A request can enter every cycle unless the skid entry
// is full. Stages: 5 geometry, 16 divider (one per bit of u), 4 foot/square,
// 34 square-root (one per root bit), and the output register. A two-entry
// output buffer keeps the pipeline taking requests while a result waits.
module segment_point_box_zone_query_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  spbz_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output spbz_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [spbz_pkg::COORD_W-1:0]  cfg_data_i
);

  // segment registers
  spbz_pkg::seg_t seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q.src_x <= '0;
      seg_q.src_y <= '0;
      seg_q.dst_x <= spbz_pkg::SEG_DST_X_RST;
      seg_q.dst_y <= '0;
    end else if (cfg_we_i) begin
      case (spbz_pkg::reg_idx_e'(cfg_index_i))
        spbz_pkg::REG_SRC_X: seg_q.src_x <= cfg_data_i;
        spbz_pkg::REG_SRC_Y: seg_q.src_y <= cfg_data_i;
        spbz_pkg::REG_DST_X: seg_q.dst_x <= cfg_data_i;
        spbz_pkg::REG_DST_Y: seg_q.dst_y <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the skid entry is occupied
  logic adv;
  logic skid_v_q, out_v_q;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  // geometry: differences, products, dot/cross sums, zones, box rules
  logic                       fr_v;
  logic [spbz_pkg::DEN_W-1:0] fr_dot, fr_den;
  spbz_pkg::geo_t             fr_geo;
  spbz_pkg::flags_t           fr_flags;

  spbz_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .seg_i   (seg_q),
    .valid_o (fr_v),
    .dot_o   (fr_dot),
    .den_o   (fr_den),
    .geo_o   (fr_geo),
    .flags_o (fr_flags)
  );

  // u = dot / den for the interior zone
  logic                        dv_v;
  logic [spbz_pkg::U_FRAC-1:0] dv_uq;
  spbz_pkg::geo_t              dv_geo;
  spbz_pkg::flags_t            dv_flags;

  spbz_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_v),
    .dot_i   (fr_dot),
    .den_i   (fr_den),
    .geo_i   (fr_geo),
    .flags_i (fr_flags),
    .valid_o (dv_v),
    .uq_o    (dv_uq),
    .geo_o   (dv_geo),
    .flags_o (dv_flags)
  );

  // foot point and squared distance
  logic                       ds_v;
  logic [spbz_pkg::RAD_W-1:0] ds_dsq;
  logic [spbz_pkg::UQ_W-1:0]  ds_uq;
  spbz_pkg::flags_t           ds_flags;

  spbz_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (dv_v),
    .uq_i    (dv_uq),
    .geo_i   (dv_geo),
    .flags_i (dv_flags),
    .valid_o (ds_v),
    .dsq_o   (ds_dsq),
    .uq_o    (ds_uq),
    .flags_o (ds_flags)
  );

  // floor square root
  logic                        sq_v;
  logic [spbz_pkg::DIST_W-1:0] sq_root;
  logic [spbz_pkg::UQ_W-1:0]   sq_uq;
  spbz_pkg::flags_t            sq_flags;

  spbz_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ds_v),
    .dsq_i   (ds_dsq),
    .uq_i    (ds_uq),
    .flags_i (ds_flags),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .uq_o    (sq_uq),
    .flags_o (sq_flags)
  );

  // result formatting
  spbz_pkg::out_t res;
  logic           res_in;

  always_comb begin
    res_in                 = sq_flags.zone == spbz_pkg::ZONE_IN;
    res.dist_res           = sq_root;
    res.proj_u             = sq_uq;
    res.star_dist          = res_in ? sq_root : '1;
    res.star_far           = !res_in;
    res.zone_sign          = sq_flags.zone;
    res.right_side         = sq_flags.right;
    res.point_in_zone      = res_in;
    res.point_in_zone_star = res_in && sq_flags.right;
    res.box_in_zone        = sq_flags.bz;
    res.box_in_zone_star   = sq_flags.bzs;
    res.on_segment         = sq_flags.onseg;
    res.degenerate         = sq_flags.degen;
  end

  // output register plus skid entry
  spbz_pkg::out_t out_q, skid_q;
  logic           out_free;

  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_free) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (sq_v) begin
      if (out_free) out_v_q  <= 1'b1;
      else          skid_v_q <= 1'b1;
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) out_q <= skid_q;
    end else if (sq_v) begin
      if (out_free) out_q  <= res;
      else          skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // skid entry is only used behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry valid without output valid");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid filled while output was free");

  a_star_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.star_far == (out_q.zone_sign != spbz_pkg::ZONE_IN)))
    else $error("star_far disagrees with zone");

  a_degen_u: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.degenerate) |-> (out_q.proj_u == '0 && !out_q.right_side))
    else $error("degenerate segment with nonzero u or right side");

  a_box_star: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.box_in_zone_star) |-> out_q.box_in_zone)
    else $error("box star flag without box zone flag");

endmodule

// ===== test/segment_point_box_zone_query_unit_test.sv =====
module segment_point_box_zone_query_unit_test;
  import spbz_pkg::*;

  // Wide signed arithmetic: every product of the exact tests fits with room to spare.
  typedef logic signed [135:0] wide_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  in_t            in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b1;
  out_t           out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_index_i = REG_SRC_X;
  logic [COORD_W-1:0] cfg_data_i = '0;

  // Local copy of the segment registers, tracked on every write.
  logic signed [COORD_W-1:0] wall_sx, wall_sy, wall_dx, wall_dy;

  out_t pending_results[$];
  int   mismatches = 0;
  bit   idle_on = 1'b1;     // random gaps on both sides
  int   ready_hold = 0;     // requested long receiver hold-off, in cycles

  segment_point_box_zone_query_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Limit: far beyond the slowest correct run (~650 requests, all stalls).
  initial begin
    #20000000;
    $display("segment_point_box_zone_query_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic wide_t mag(wide_t a);
    return a < 0 ? -a : a;
  endfunction

  // Zone of offset (px,py) from src against segment vector (dx,dy); exact.
  function automatic void zone_of(input wide_t px, py, dx, dy,
                                  output zone_e z, output logic rt, output logic col,
                                  output wide_t dot, output wide_t den);
    wide_t cr;
    dot = px * dx + py * dy;
    den = dx * dx + dy * dy;
    cr  = dx * py - dy * px;
    rt  = cr < 0;
    col = cr == 0;
    if (dot <= 0) z = ZONE_BEFORE;
    else if (dot >= den) z = ZONE_AFTER;
    else z = ZONE_IN;
  endfunction

  function automatic out_t predict_query(in_t q);
    int    sgx[4] = '{-1, 1, 1, -1};
    int    sgy[4] = '{-1, -1, 1, 1};
    wide_t cx, cy, w, h, x1, y1, x2, y2, dx, dy, px, py;
    wide_t dot, den, uqw, ex, ey, dsq, r, t, qx, qy, d1, d2;
    zone_e z, zc[4];
    logic  rt, col, rc[4], cl, bz, bzs, onseg;
    int    nright;
    out_t  o;
    cx = q.center_x;  cy = q.center_y;
    w  = q.box_width; h  = q.box_height;
    x1 = wall_sx; y1 = wall_sy; x2 = wall_dx; y2 = wall_dy;
    dx = x2 - x1; dy = y2 - y1; px = cx - x1; py = cy - y1;
    zone_of(px, py, dx, dy, z, rt, col, dot, den);
    if (z == ZONE_AFTER) uqw = wide_t'(1) <<< U_FRAC;
    else if (z == ZONE_IN) uqw = (dot <<< U_FRAC) / den;
    else uqw = 0;
    // Foot point rounded half up, floor shift.
    ex  = px - ((uqw * dx + U_HALF) >>> U_FRAC);
    ey  = py - ((uqw * dy + U_HALF) >>> U_FRAC);
    dsq = ex * ex + ey * ey;
    r = 0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      t = r | (wide_t'(1) <<< b);
      if (t * t <= dsq) r = t;
    end
    onseg = col && cx >= (x1 < x2 ? x1 : x2) && cx <= (x1 < x2 ? x2 : x1) &&
            cy >= (y1 < y2 ? y1 : y2) && cy <= (y1 < y2 ? y2 : y1);
    // Corners at doubled coordinates so the half size stays exact.
    nright = 0;
    for (int k = 0; k < 4; k++) begin
      qx = 2 * cx + sgx[k] * w - 2 * x1;
      qy = 2 * cy + sgy[k] * h - 2 * y1;
      zone_of(qx, qy, 2 * dx, 2 * dy, zc[k], rc[k], cl, d1, d2);
      if (rc[k]) nright++;
    end
    bz = (mag(2 * x1 - 2 * cx) <= w && mag(2 * y1 - 2 * cy) <= h) ||
         (mag(2 * x2 - 2 * cx) <= w && mag(2 * y2 - 2 * cy) <= h);
    for (int k = 0; k < 4; k++)
      if (zc[k] == ZONE_IN || zc[k] != zc[(k + 1) % 4]) bz = 1'b1;
    bzs = 1'b0;
    if (bz && nright > 0)
      for (int k = 0; k < 4; k++) begin
        if (rc[k] && zc[k] == ZONE_IN) bzs = 1'b1;
        if ((rc[k] || rc[(k + 1) % 4]) && zc[k] != zc[(k + 1) % 4]) bzs = 1'b1;
      end
    o.dist_res           = r[DIST_W-1:0];
    o.proj_u             = uqw[UQ_W-1:0];
    o.star_dist          = (z == ZONE_IN) ? r[DIST_W-1:0] : '1;
    o.star_far           = z != ZONE_IN;
    o.zone_sign          = z;
    o.right_side         = rt;
    o.point_in_zone      = z == ZONE_IN;
    o.point_in_zone_star = z == ZONE_IN && rt;
    o.box_in_zone        = bz;
    o.box_in_zone_star   = bzs;
    o.on_segment         = onseg;
    o.degenerate         = dx == 0 && dy == 0;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  task automatic send_query(in_t q);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= q;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_query(q));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (70) @(posedge clk_i);
  endtask

  // Segment registers are only touched with the pipe empty.
  task automatic load_wall(logic signed [31:0] sx, sy, ex, ey);
    wait_drained();
    cfg_we_i <= 1'b1; cfg_index_i <= REG_SRC_X; cfg_data_i <= sx; @(posedge clk_i);
    cfg_index_i <= REG_SRC_Y; cfg_data_i <= sy; @(posedge clk_i);
    cfg_index_i <= REG_DST_X; cfg_data_i <= ex; @(posedge clk_i);
    cfg_index_i <= REG_DST_Y; cfg_data_i <= ey; @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wall_sx = sx; wall_sy = sy; wall_dx = ex; wall_dy = ey;
  endtask

  function automatic in_t make_query(logic signed [31:0] x, y, logic [30:0] w, h);
    in_t q;
    q.center_x = x; q.center_y = y; q.box_width = w; q.box_height = h;
    return q;
  endfunction

  // Random request: mostly near the wall so every zone and box case shows up.
  function automatic in_t random_query();
    logic signed [31:0] x, y;
    logic [30:0] w, h;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      x = $urandom; y = $urandom;
    end else begin
      x = wall_sx + ((wall_dx - wall_sx) >>> $urandom_range(0, 3)) +
          $signed($urandom_range(0, 2 ** 18)) - (2 ** 17);
      y = wall_sy + ((wall_dy - wall_sy) >>> $urandom_range(0, 3)) +
          $signed($urandom_range(0, 2 ** 18)) - (2 ** 17);
      if (mode == 9) begin
        x = wall_sx; y = wall_sy;  // collinear / endpoint hits
      end
    end
    case ($urandom_range(0, 3))
      0: begin w = $urandom; h = $urandom; end
      1: begin w = 0; h = 0; end
      default: begin w = $urandom_range(0, 2 ** 19); h = $urandom_range(0, 2 ** 19); end
    endcase
    return make_query(x, y, w, h);
  endfunction

  function automatic logic signed [31:0] random_coord();
    return ($urandom_range(0, 4) == 0) ? $signed($urandom)
                                        : $signed($urandom_range(0, 2 ** 22)) - (2 ** 21);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random bursts of backpressure, plus an on-demand long hold-off.
  // ---------------------------------------------------------------------------
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (ready_hold > 0) begin
        out_ready_i <= 1'b0;
        ready_hold--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 15);
        out_ready_i <= 1'b0;
        repeat (burst - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Result checker: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data_o.dist_res !== exp_r.dist_res) begin
          $error("dist_res exp %0d got %0d", exp_r.dist_res, out_data_o.dist_res); mismatches++;
        end
        if (out_data_o.proj_u !== exp_r.proj_u) begin
          $error("proj_u exp %0d got %0d", exp_r.proj_u, out_data_o.proj_u); mismatches++;
        end
        if (out_data_o.star_dist !== exp_r.star_dist) begin
          $error("star_dist exp %0d got %0d", exp_r.star_dist, out_data_o.star_dist);
          mismatches++;
        end
        if (out_data_o.star_far !== exp_r.star_far) begin
          $error("star_far exp %0d got %0d", exp_r.star_far, out_data_o.star_far); mismatches++;
        end
        if (out_data_o.zone_sign !== exp_r.zone_sign) begin
          $error("zone_sign exp %0d got %0d", exp_r.zone_sign, out_data_o.zone_sign);
          mismatches++;
        end
        if (out_data_o.right_side !== exp_r.right_side) begin
          $error("right_side exp %0d got %0d", exp_r.right_side, out_data_o.right_side);
          mismatches++;
        end
        if (out_data_o.point_in_zone !== exp_r.point_in_zone) begin
          $error("point_in_zone exp %0d got %0d", exp_r.point_in_zone,
                 out_data_o.point_in_zone);
          mismatches++;
        end
        if (out_data_o.point_in_zone_star !== exp_r.point_in_zone_star) begin
          $error("point_in_zone_star exp %0d got %0d", exp_r.point_in_zone_star,
                 out_data_o.point_in_zone_star);
          mismatches++;
        end
        if (out_data_o.box_in_zone !== exp_r.box_in_zone) begin
          $error("box_in_zone exp %0d got %0d", exp_r.box_in_zone, out_data_o.box_in_zone);
          mismatches++;
        end
        if (out_data_o.box_in_zone_star !== exp_r.box_in_zone_star) begin
          $error("box_in_zone_star exp %0d got %0d", exp_r.box_in_zone_star,
                 out_data_o.box_in_zone_star);
          mismatches++;
        end
        if (out_data_o.on_segment !== exp_r.on_segment) begin
          $error("on_segment exp %0d got %0d", exp_r.on_segment, out_data_o.on_segment);
          mismatches++;
        end
        if (out_data_o.degenerate !== exp_r.degenerate) begin
          $error("degenerate exp %0d got %0d", exp_r.degenerate, out_data_o.degenerate);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset wall (0,0)->(1,0): extremes, each zone, sides, endpoints, box cases.
  task automatic test_directed();
    send_query(make_query(32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
    send_query(make_query(32'sh80000000, 32'sh80000000, 31'h7FFFFFFF, 31'h7FFFFFFF));
    send_query(make_query(32'sh80000000, 32'sh7FFFFFFF, 0, 0));
    send_query(make_query(-32'sd65536, 0, 0, 0));          // before src, collinear
    send_query(make_query(0, 0, 0, 0));                    // on src
    send_query(make_query(32'sd32768, 0, 0, 0));           // mid, on segment
    send_query(make_query(32'sd65536, 0, 0, 0));           // on dst
    send_query(make_query(32'sd131072, 0, 0, 0));          // past dst
    send_query(make_query(32'sd21845, -32'sd65536, 0, 0)); // right side
    send_query(make_query(32'sd21845, 32'sd65536, 0, 0));  // left side
    send_query(make_query(32'sd1, 32'sd1, 0, 0));          // barely inside
    send_query(make_query(32'sd65535, -32'sd1, 0, 0));
    send_query(make_query(-32'sd65536, -32'sd65536, 31'd131072, 31'd131072)); // corner on src
    send_query(make_query(32'sd32768, 32'sd65536, 31'd4, 31'd131072));  // box touches wall
    send_query(make_query(-32'sd200000, -32'sd1000, 31'd10, 31'd10));   // box fully before
    send_query(make_query(32'sd300000, 32'sd5, 31'd500000, 31'd2));     // box spans in and after zones
    send_query(make_query(32'sd40000, -32'sd90000, 31'd7, 31'd9));      // odd size, right
  endtask

  task automatic test_wall_settings();
    load_wall(32'sd100, 32'sd100, 32'sd100, 32'sd100);     // degenerate wall
    send_query(make_query(32'sd100, 32'sd100, 0, 0));
    send_query(make_query(32'sd101, 32'sd100, 31'd2, 31'd0));
    send_query(make_query(-32'sd5000, 32'sd7000, 31'd3, 31'd3));
    load_wall(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_query(make_query(0, 0, 0, 0));
    send_query(make_query(-32'sd1, 0, 0, 0));
    send_query(make_query(32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 0));
    send_query(make_query(32'sh80000000, 32'sh7FFFFFFF, 0, 31'h7FFFFFFF));
    load_wall(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
    send_query(make_query(0, 0, 31'd1, 31'd1));
    send_query(make_query(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0));
  endtask

  // Long receiver hold-off with the sender streaming: pipe fills, input stalls.
  task automatic test_backpressure();
    load_wall(-32'sd65536, 32'sd30000, 32'sd131072, -32'sd50000);
    ready_hold = 300;
    for (int i = 0; i < 120; i++) send_query(random_query());
  endtask

  // Random queries, new wall per 60; once per 45 the sender waits for every pending result.
  task automatic test_pause_and_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0)
        load_wall(random_coord(), random_coord(), random_coord(), random_coord());
      if (i % 45 == 20) wait_drained();
      send_query(random_query());
    end
  endtask

  initial begin
    wall_sx = 0; wall_sy = 0; wall_dx = SEG_DST_X_RST; wall_dy = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_wall_settings();
    test_backpressure();
    test_pause_and_random(380);
    // Final stretch with no gaps on either side.
    wait_drained();
    idle_on = 1'b0;
    test_pause_and_random(100);
    wait_drained();
    if (mismatches == 0)
      $display("segment_point_box_zone_query_unit regression: pass");
    else
      $display("segment_point_box_zone_query_unit regression: fail");
    $finish;
  end

endmodule
